// ===== src/q15_float_format_converter_macros.svh =====
// Assertion macros for the q15 / float32 converter
`ifndef Q15_FLOAT_FORMAT_CONVERTER_MACROS_SVH
`define Q15_FLOAT_FORMAT_CONVERTER_MACROS_SVH
`ifndef SYNTH
// condition a implies condition b in the same cycle
`define Q15F_ASSERT_IMPL(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("q15f: check failed");
// condition a implies condition b in the next cycle
`define Q15F_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("q15f: check failed");
`else
`define Q15F_ASSERT_IMPL(lbl, a, b)
`define Q15F_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ===== src/q15f_pkg.sv =====
package q15f_pkg;

    // scale 33000 and floor(2^41 / 33000) for the reciprocal divide
    localparam logic [15:0] SCALE       = 16'd33000;
    localparam logic [25:0] RECIP       = 26'd66637068;
    localparam logic [7:0]  EXP_MAX     = 8'hFF;

    // decoded word
    typedef struct packed {
        logic        dir;
        logic        sign;
        logic        q_zero;
        logic [15:0] q_norm;
        logic [3:0]  q_shift;
        logic        f_nan;
        logic        f_inf;
        logic        f_tiny;
        logic [7:0]  f_exp;
        logic [23:0] f_man;
    } s1_t;

    // products
    typedef struct packed {
        logic        dir;
        logic        sign;
        logic        q_zero;
        logic [15:0] q_norm;
        logic [3:0]  q_shift;
        logic [41:0] q_prod;
        logic        f_nan;
        logic        f_inf;
        logic        f_tiny;
        logic [7:0]  f_exp;
        logic [39:0] f_prod;
    } s2_t;

    // corrected quotient / rounded product
    typedef struct packed {
        logic        dir;
        logic        sign;
        logic        q_zero;
        logic [3:0]  q_shift;
        logic [25:0] q_quot;
        logic        q_sticky;
        logic        f_nan;
        logic        f_inf;
        logic        f_tiny;
        logic [24:0] f_mant;
        logic [9:0]  f_sh;
    } s3_t;

    // result word
    typedef struct packed {
        logic        dir;
        logic [31:0] sample;
        logic        flag;
    } res_t;

endpackage

// ===== src/q15f_decode.sv =====
module q15f_decode
(
    input  logic             clk,
    input  logic             en,
    input  logic             dir,
    input  logic [31:0]      sample_in,
    output q15f_pkg::s1_t    s1_reg
);
    import q15f_pkg::*;

    s1_t         s1_next;
    logic [15:0] mag;
    logic [3:0]  lz;

    // magnitude of the q15 sample and its leading zero count
    always_comb
    begin
        mag = sample_in[15] ? 16'(~sample_in[15:0] + 16'd1) : sample_in[15:0];
        lz  = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (mag[i])
            begin
                lz = 4'(15 - i);
            end
        end
    end

    // field split for both directions
    always_comb
    begin
        s1_next.dir     = dir;
        s1_next.sign    = dir ? sample_in[31] : sample_in[15];
        s1_next.q_zero  = (mag == 16'd0);
        s1_next.q_norm  = mag << lz;
        s1_next.q_shift = lz;
        s1_next.f_exp   = sample_in[30:23];
        s1_next.f_man   = {1'b1, sample_in[22:0]};
        s1_next.f_nan   = (sample_in[30:23] == EXP_MAX) && (sample_in[22:0] != 23'd0);
        s1_next.f_inf   = (sample_in[30:23] == EXP_MAX) && (sample_in[22:0] == 23'd0);
        s1_next.f_tiny  = (sample_in[30:23] == 8'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

endmodule

// ===== src/q15f_mult.sv =====
module q15f_mult
(
    input  logic             clk,
    input  logic             en,
    input  q15f_pkg::s1_t    s1,
    output q15f_pkg::s2_t    s2_reg
);
    import q15f_pkg::*;

    s2_t s2_next;

    // reciprocal product for the divide, scale product for the multiply
    always_comb
    begin
        s2_next.dir     = s1.dir;
        s2_next.sign    = s1.sign;
        s2_next.q_zero  = s1.q_zero;
        s2_next.q_norm  = s1.q_norm;
        s2_next.q_shift = s1.q_shift;
        s2_next.q_prod  = 42'(s1.q_norm) * 42'(RECIP);
        s2_next.f_nan   = s1.f_nan;
        s2_next.f_inf   = s1.f_inf;
        s2_next.f_tiny  = s1.f_tiny;
        s2_next.f_exp   = s1.f_exp;
        s2_next.f_prod  = 40'(s1.f_man) * 40'(SCALE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

endmodule

// ===== src/q15f_correct.sv =====
module q15f_correct
(
    input  logic             clk,
    input  logic             en,
    input  q15f_pkg::s2_t    s2,
    output q15f_pkg::s3_t    s3_reg
);
    import q15f_pkg::*;

    s3_t         s3_next;
    logic [25:0] q0;
    logic [41:0] back;
    logic [17:0] rem;
    logic [17:0] rem_fix;
    logic        bump;
    logic        top;
    logic [23:0] m;
    logic        g;
    logic        st;
    logic        rnd;

    // quotient estimate is low by at most one; fix with the remainder
    always_comb
    begin
        q0      = s2.q_prod[41:16];
        back    = 42'(q0) * 42'(SCALE);
        rem     = 18'({1'b0, s2.q_norm, 25'd0} - back);
        bump    = (rem >= 18'(SCALE));
        rem_fix = bump ? 18'(rem - 18'(SCALE)) : rem;
    end

    // round the scaled float to 24 significant bits, nearest even
    always_comb
    begin
        top = s2.f_prod[39];
        if (top)
        begin
            m  = s2.f_prod[39:16];
            g  = s2.f_prod[15];
            st = |s2.f_prod[14:0];
        end
        else
        begin
            m  = s2.f_prod[38:15];
            g  = s2.f_prod[14];
            st = |s2.f_prod[13:0];
        end
        rnd = g & (st | m[0]);
    end

    always_comb
    begin
        s3_next.dir      = s2.dir;
        s3_next.sign     = s2.sign;
        s3_next.q_zero   = s2.q_zero;
        s3_next.q_shift  = s2.q_shift;
        s3_next.q_quot   = q0 + 26'(bump);
        s3_next.q_sticky = (rem_fix != 18'd0);
        s3_next.f_nan    = s2.f_nan;
        s3_next.f_inf    = s2.f_inf;
        s3_next.f_tiny   = s2.f_tiny;
        s3_next.f_mant   = 25'(m) + 25'(rnd);
        s3_next.f_sh     = 10'({2'b00, s2.f_exp}) - 10'd134 - 10'(!top);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
        end
    end

endmodule

// ===== src/q15f_pack.sv =====
module q15f_pack
(
    input  logic             clk,
    input  logic             en,
    input  q15f_pkg::s3_t    s3,
    output q15f_pkg::res_t   res_reg
);
    import q15f_pkg::*;

    res_t        res_next;
    logic        top;
    logic [23:0] mant;
    logic        g;
    logic        st;
    logic [24:0] mr;
    logic [7:0]  fexp;
    logic [31:0] fword;
    logic [7:0]  amt;
    logic [24:0] ipart;
    logic [31:0] qword;
    logic        qflag;

    // float packing of the quotient, nearest even
    always_comb
    begin
        top = s3.q_quot[25];
        if (top)
        begin
            mant = s3.q_quot[25:2];
            g    = s3.q_quot[1];
            st   = s3.q_quot[0] | s3.q_sticky;
        end
        else
        begin
            mant = s3.q_quot[24:1];
            g    = s3.q_quot[0];
            st   = s3.q_sticky;
        end
        mr   = 25'(mant) + 25'(g & (st | mant[0]));
        fexp = 8'd127 - 8'(s3.q_shift) - 8'(!top) + 8'(mr[24]);
        if (s3.q_zero)
        begin
            fword = 32'd0;
        end
        else
        begin
            fword = {s3.sign, fexp, (mr[24] ? 23'd0 : mr[22:0])};
        end
    end

    // truncate toward zero and saturate
    always_comb
    begin
        amt   = 8'(-s3.f_sh);
        ipart = s3.f_mant >> amt;
        qword = 32'd0;
        qflag = 1'b0;
        if (s3.f_nan)
        begin
            qflag = 1'b1;
        end
        else if (s3.f_tiny)
        begin
            qword = 32'd0;
        end
        else if (s3.f_inf || !s3.f_sh[9])
        begin
            qword = s3.sign ? 32'h0000_8000 : 32'h0000_7FFF;
            qflag = 1'b1;
        end
        else if (!s3.sign && ipart >= 25'd32768)
        begin
            qword = 32'h0000_7FFF;
            qflag = 1'b1;
        end
        else if (s3.sign && ipart >= 25'd32769)
        begin
            qword = 32'h0000_8000;
            qflag = 1'b1;
        end
        else
        begin
            qword = {16'd0, (s3.sign ? 16'(~ipart[15:0] + 16'd1) : ipart[15:0])};
        end
    end

    always_comb
    begin
        res_next.dir    = s3.dir;
        res_next.sample = s3.dir ? qword : fword;
        res_next.flag   = s3.dir ? qflag : 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== src/q15_float_format_converter.sv =====
// Pipeline: four register stages (decode, multiply, correct, pack); out_valid
// rises once the accepted word has reached the pack stage register.
// Throughput: one word per cycle while out_ready is high; a full stage holds only
// while the stage after it is full and held, so bubbles close up.
// Reset: rst_n clears all valid bits and sets the direction register dir_reg to 0
// (q15 to float32); the payload registers are not reset.
`include "q15_float_format_converter_macros.svh"
module q15_float_format_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        conversion_direction,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] sample_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] sample_out,
    output logic        out_of_range
);
    import q15f_pkg::*;

    logic       dir_reg;
    logic [3:0] v_reg;
    logic [3:0] v_next;
    logic [3:0] en;
    s1_t        s1;
    s2_t        s2;
    s3_t        s3;
    res_t       res;

    // direction register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            dir_reg <= conversion_direction;
        end
    end

    // per-stage enables: a stage loads when empty or when its word moves on
    assign en[3]    = !v_reg[3] || out_ready;
    assign en[2]    = !v_reg[2] || en[3];
    assign en[1]    = !v_reg[1] || en[2];
    assign en[0]    = !v_reg[0] || en[1];
    assign in_ready = en[0];

    always_comb
    begin
        v_next = v_reg;
        if (en[0]) v_next[0] = in_valid;
        if (en[1]) v_next[1] = v_reg[0];
        if (en[2]) v_next[2] = v_reg[1];
        if (en[3]) v_next[3] = v_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 4'd0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    q15f_decode u_decode
    (
        .clk       (clk),
        .en        (en[0]),
        .dir       (dir_reg),
        .sample_in (sample_in),
        .s1_reg    (s1)
    );

    q15f_mult u_mult
    (
        .clk    (clk),
        .en     (en[1]),
        .s1     (s1),
        .s2_reg (s2)
    );

    q15f_correct u_correct
    (
        .clk    (clk),
        .en     (en[2]),
        .s2     (s2),
        .s3_reg (s3)
    );

    q15f_pack u_pack
    (
        .clk     (clk),
        .en      (en[3]),
        .s3      (s3),
        .res_reg (res)
    );

    assign out_valid    = v_reg[3];
    assign sample_out   = res.sample;
    assign out_of_range = res.flag;

    // checks
    `Q15F_ASSERT_IMPL(a_empty_ready, !v_reg[3], in_ready)
    `Q15F_ASSERT_IMPL(a_q2f_noflag, out_valid && !res.dir, !out_of_range)
    `Q15F_ASSERT_IMPL(a_f2q_upper, out_valid && res.dir, sample_out[31:16] == 16'd0)
    `Q15F_ASSERT_IMPL(a_flag_value, out_valid && out_of_range,
        sample_out == 32'h0000_7FFF || sample_out == 32'h0000_8000 || sample_out == 32'd0)
    `Q15F_ASSERT_NEXT(a_feed, in_valid && in_ready, v_reg[0])

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [63:0] SCALE_INT = 64'd33000;
    localparam logic DIR_Q15_TO_FLOAT = 1'b0;
    localparam logic DIR_FLOAT_TO_Q15 = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        conversion_direction = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] sample_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] sample_out;
    logic        out_of_range;

    // one converted word as it should leave the block
    typedef struct packed {
        logic [31:0] word;
        logic        flag;
    } conv_t;

    // directed row; known rows carry their own expected result
    typedef struct packed {
        logic        dir;
        logic [31:0] word;
        logic        known;
        logic [31:0] res;
        logic        flag;
    } row_t;

    conv_t pending_words[$];
    logic  dir_now = DIR_Q15_TO_FLOAT;
    bit    quiet = 1'b0;
    int    mismatches = 0;
    int    stall_count = 0;

    q15_float_format_converter u_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .conversion_direction (conversion_direction),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .sample_in            (sample_in),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .sample_out           (sample_out),
        .out_of_range         (out_of_range)
    );

    always #5 clk = ~clk;

    // q15 / 33000 in single precision, round to nearest even, done in integers
    function automatic conv_t q15_to_float(logic [15:0] q);
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] m;
        logic [63:0] rem;
        int          k;
        conv_t       r;
        mag = q[15] ? (64'd65536 - {48'd0, q}) : {48'd0, q};
        m = 0;
        rem = 0;
        r.flag = 1'b0;
        if (mag == 0)
        begin
            r.word = 32'd0;
            return r;
        end
        for (k = 0; k <= 48; k++)
        begin
            num = mag << k;
            m = num / SCALE_INT;
            rem = num % SCALE_INT;
            if (m >= 64'h80_0000)
                break;
        end
        if ((2 * rem > SCALE_INT) || ((2 * rem == SCALE_INT) && m[0]))
            m = m + 1;
        if (m == 64'h100_0000)
        begin
            m = m >> 1;
            k = k - 1;
        end
        r.word = {q[15], 8'(150 - k), m[22:0]};
        return r;
    endfunction

    // float * 33000 rounded to single, then truncated and saturated to q15
    function automatic conv_t float_to_q15(logic [31:0] f);
        logic [63:0] p;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] ival;
        int          len;
        int          sh;
        int          s;
        conv_t       r;
        r.flag = 1'b0;
        r.word = 32'd0;
        if (f[30:23] == 8'hFF)
        begin
            r.flag = 1'b1;
            if (f[22:0] == 0)
                r.word = f[31] ? 32'h8000 : 32'h7FFF;
            return r;
        end
        // zero and subnormals stay below one after scaling
        if (f[30:23] == 8'h00)
            return r;
        p = {40'd0, 1'b1, f[22:0]} * SCALE_INT;
        len = 0;
        for (int i = 0; i < 64; i++)
            if (p[i])
                len = i + 1;
        sh = (len > 24) ? len - 24 : 0;
        mant = p >> sh;
        if (sh > 0)
        begin
            rem = p & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if ((rem > half) || ((rem == half) && mant[0]))
                mant = mant + 1;
        end
        s = int'(f[30:23]) - 127 - 23 + sh;
        if (s > 20)
            ival = 64'd65536;
        else if (s >= 0)
            ival = mant << s;
        else if (s < -40)
            ival = 0;
        else
            ival = mant >> (-s);
        if (!f[31])
        begin
            if (ival >= 64'd32768)
            begin
                r.word = 32'h7FFF;
                r.flag = 1'b1;
            end
            else
                r.word = {16'd0, ival[15:0]};
        end
        else
        begin
            if (ival >= 64'd32769)
            begin
                r.word = 32'h8000;
                r.flag = 1'b1;
            end
            else
                r.word = {16'd0, 16'(-ival[15:0])};
        end
        return r;
    endfunction

    function automatic conv_t convert_word(logic dir, logic [31:0] w);
        if (dir == DIR_Q15_TO_FLOAT)
            return q15_to_float(w[15:0]);
        return float_to_q15(w);
    endfunction

    function automatic bit take_break();
        return !quiet && ($urandom_range(99) < 17);
    endfunction

    task automatic wait_drained();
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // register write only once the pipe has emptied
    task automatic set_direction(logic d);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        conversion_direction <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        dir_now = d;
    endtask

    // send one word; expectation is queued at the accepting edge
    task automatic send_word(logic [31:0] w, bit known, conv_t known_res);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= w;
        do
            @(posedge clk);
        while (!in_ready);
        pending_words.push_back(known ? known_res : convert_word(dir_now, w));
    endtask

    function automatic logic [31:0] float_stimulus();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(9))
            0, 1: ;
            8: w[30:23] = 8'hFF;
            9: w[30:23] = 8'h00;
            default: w[30:23] = 8'($urandom_range(142, 108));
        endcase
        return w;
    endfunction

    // receiver back-pressure
    always @(posedge clk)
        out_ready <= !take_break();

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: sample_out=%h out_of_range=%b",
                             sample_out, out_of_range);
            end
            else
            begin
                conv_t want;
                want = pending_words.pop_front();
                if (sample_out !== want.word || out_of_range !== want.flag)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: sample_out exp %h got %h, out_of_range exp %b got %b",
                                 want.word, sample_out, want.flag, out_of_range);
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        row_t  vectors [] = '{
            // q15 to float: zero, extremes, upper bits ignored
            '{DIR_Q15_TO_FLOAT, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
            '{DIR_Q15_TO_FLOAT, 32'h0000_7FFF, 1'b0, 32'h0, 1'b0},
            '{DIR_Q15_TO_FLOAT, 32'h0000_8000, 1'b0, 32'h0, 1'b0},
            '{DIR_Q15_TO_FLOAT, 32'h0000_FFFF, 1'b0, 32'h0, 1'b0},
            '{DIR_Q15_TO_FLOAT, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
            '{DIR_Q15_TO_FLOAT, 32'hABCD_0005, 1'b0, 32'h0, 1'b0},
            '{DIR_Q15_TO_FLOAT, 32'hFFFF_0000, 1'b1, 32'h0000_0000, 1'b0},
            // float to q15: NaNs, infinities, zeros, tiny, saturation
            '{DIR_FLOAT_TO_Q15, 32'h7FC0_0000, 1'b1, 32'h0000_0000, 1'b1},
            '{DIR_FLOAT_TO_Q15, 32'h7F80_0001, 1'b1, 32'h0000_0000, 1'b1},
            '{DIR_FLOAT_TO_Q15, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
            '{DIR_FLOAT_TO_Q15, 32'h7F80_0000, 1'b1, 32'h0000_7FFF, 1'b1},
            '{DIR_FLOAT_TO_Q15, 32'hFF80_0000, 1'b1, 32'h0000_8000, 1'b1},
            '{DIR_FLOAT_TO_Q15, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0},
            '{DIR_FLOAT_TO_Q15, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b0},
            '{DIR_FLOAT_TO_Q15, 32'h807F_FFFF, 1'b1, 32'h0000_0000, 1'b0},
            '{DIR_FLOAT_TO_Q15, 32'h3F80_0000, 1'b1, 32'h0000_7FFF, 1'b1},
            '{DIR_FLOAT_TO_Q15, 32'hBF80_0000, 1'b1, 32'h0000_8000, 1'b1},
            '{DIR_FLOAT_TO_Q15, 32'h7F7F_FFFF, 1'b1, 32'h0000_7FFF, 1'b1},
            // near the saturation edges
            '{DIR_FLOAT_TO_Q15, 32'h3F7E_3344, 1'b0, 32'h0, 1'b0},
            '{DIR_FLOAT_TO_Q15, 32'h3F7E_3345, 1'b0, 32'h0, 1'b0},
            '{DIR_FLOAT_TO_Q15, 32'hBF7E_3345, 1'b0, 32'h0, 1'b0},
            '{DIR_FLOAT_TO_Q15, 32'hBF7E_3400, 1'b0, 32'h0, 1'b0},
            '{DIR_FLOAT_TO_Q15, 32'h3800_0000, 1'b0, 32'h0, 1'b0},
            // back to q15 mode
            '{DIR_Q15_TO_FLOAT, 32'h1234_4321, 1'b0, 32'h0, 1'b0}
        };
        logic  phase_dir [5] = '{DIR_FLOAT_TO_Q15, DIR_Q15_TO_FLOAT, DIR_FLOAT_TO_Q15,
                                 DIR_Q15_TO_FLOAT, DIR_FLOAT_TO_Q15};
        conv_t none;
        logic [31:0] w;

        none = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_direction(DIR_Q15_TO_FLOAT);

        // directed table
        foreach (vectors[i])
        begin
            if (vectors[i].dir != dir_now)
            begin
                in_valid <= 1'b0;
                set_direction(vectors[i].dir);
            end
            send_word(vectors[i].word, vectors[i].known,
                      '{word: vectors[i].res, flag: vectors[i].flag});
        end

        // random phases, alternating direction
        foreach (phase_dir[ph])
        begin
            in_valid <= 1'b0;
            set_direction(phase_dir[ph]);
            quiet = (ph == 2);
            for (int n = 0; n < 260; n++)
            begin
                if (ph == 1 && n == 120)
                begin
                    in_valid <= 1'b0;
                    wait_drained();
                end
                w = (phase_dir[ph] == DIR_FLOAT_TO_Q15) ? float_stimulus() : $urandom;
                send_word(w, 1'b0, none);
            end
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
